// ===== rtl/core/rc5_pkg.sv =====
// Shared types, constants and rotate functions for the RC5 block cipher.
`default_nettype none

package rc5_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned ROT_W      = 5;
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned ROUNDS_DEF = 16;

  localparam logic [WORD_W-1:0] MAGIC_P = 32'hb7e15163;
  localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9e3779b9;

  // Operation select carried with each input beat.
  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  // Configuration register indexes.
  typedef enum logic {
    CFG_KEY_LOW  = 1'b0,
    CFG_KEY_HIGH = 1'b1
  } rc5_cfg_idx_e;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] block_a;
    logic [WORD_W-1:0] block_b;
  } rc5_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_a;
    logic [WORD_W-1:0] out_b;
  } rc5_out_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_EXPAND,
    TOP_CIPHER
  } rc5_top_state_e;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_FILL,
    KS_MIX_A,
    KS_MIX_B
  } rc5_ks_state_e;

  // Rotate left; an amount of zero returns the word unchanged.
  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input logic [ROT_W-1:0]  s);
    logic [2*WORD_W-1:0] t;
    t = {x, x} << s;
    return t[2*WORD_W-1:WORD_W];
  endfunction

  // Rotate right; an amount of zero returns the word unchanged.
  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                             input logic [ROT_W-1:0]  s);
    logic [2*WORD_W-1:0] t;
    t = {x, x} >> s;
    return t[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rc5_subkey_ram.sv =====
// Subkey table: one write port and two registered read ports.
`default_nettype none

module rc5_subkey_ram #(
  parameter  int unsigned ROUNDS = rc5_pkg::ROUNDS_DEF,
  localparam int unsigned Depth  = 2 * ROUNDS + 2,
  localparam int unsigned AddrW  = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [rc5_pkg::WORD_W-1:0] wdata_i,
  input  logic [AddrW-1:0]           raddr0_i,
  input  logic [AddrW-1:0]           raddr1_i,
  output logic [rc5_pkg::WORD_W-1:0] rdata0_o,
  output logic [rc5_pkg::WORD_W-1:0] rdata1_o
);
  import rc5_pkg::*;

  logic [WORD_W-1:0] mem_q [Depth];
  logic [WORD_W-1:0] rdata0_q;
  logic [WORD_W-1:0] rdata1_q;

  // Write, and read on both ports with the read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

`default_nettype wire

// ===== rtl/core/rc5_key_sched.sv =====
// Key expansion sequencer: fills the subkey table and runs the mixing steps.
`default_nettype none

module rc5_key_sched #(
  parameter  int unsigned ROUNDS   = rc5_pkg::ROUNDS_DEF,
  localparam int unsigned Depth    = 2 * ROUNDS + 2,
  localparam int unsigned AddrW    = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rc5_pkg::KEY_W-1:0]  key_low_i,
  input  logic [rc5_pkg::KEY_W-1:0]  key_high_i,
  input  logic [rc5_pkg::WORD_W-1:0] rdata_i,
  output logic [AddrW-1:0]           raddr_o,
  output logic                       we_o,
  output logic [AddrW-1:0]           waddr_o,
  output logic [rc5_pkg::WORD_W-1:0] wdata_o,
  output logic                       active_o,
  output logic                       done_o
);
  import rc5_pkg::*;

  localparam int unsigned MixSteps = 3 * ((Depth > KEY_WORDS) ? Depth : KEY_WORDS);
  localparam int unsigned StepW    = $clog2(MixSteps);
  localparam int unsigned KjW      = $clog2(KEY_WORDS);
  localparam logic [ROT_W-1:0] RotA = ROT_W'(3);

  rc5_ks_state_e     state_q, state_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [KjW-1:0]    kj_q, kj_d;
  logic [WORD_W-1:0] fill_q, fill_d;
  logic [WORD_W-1:0] a_q, a_d;
  logic [WORD_W-1:0] b_q, b_d;
  logic [WORD_W-1:0] kw_q [KEY_WORDS];
  logic [WORD_W-1:0] kw_d [KEY_WORDS];
  logic [WORD_W-1:0] ab_sum;
  logic [WORD_W-1:0] a_mix;
  logic [WORD_W-1:0] b_mix;
  logic [AddrW-1:0]  idx_next;

  // Mixing arithmetic: the table word update, then the key word update.
  assign ab_sum   = a_q + b_q;
  assign a_mix    = rotl(rdata_i + ab_sum, RotA);
  assign b_mix    = rotl(kw_q[kj_q] + ab_sum, ab_sum[ROT_W-1:0]);
  assign idx_next = (idx_q == AddrW'(Depth - 1)) ? '0 : AddrW'(idx_q + 1'b1);

  // Sequencer for the fill pass and the mixing steps, each step in a MIX_A and a MIX_B state.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    step_d  = step_q;
    kj_d    = kj_q;
    fill_d  = fill_q;
    a_d     = a_q;
    b_d     = b_q;
    kw_d    = kw_q;
    we_o    = 1'b0;
    wdata_o = fill_q;
    done_o  = 1'b0;
    unique case (state_q)
      KS_IDLE: begin
        if (start_i) begin
          kw_d[0] = key_low_i[WORD_W-1:0];
          kw_d[1] = key_low_i[KEY_W-1:WORD_W];
          kw_d[2] = key_high_i[WORD_W-1:0];
          kw_d[3] = key_high_i[KEY_W-1:WORD_W];
          idx_d   = '0;
          step_d  = '0;
          kj_d    = '0;
          fill_d  = MAGIC_P;
          a_d     = '0;
          b_d     = '0;
          state_d = KS_FILL;
        end
      end
      KS_FILL: begin
        we_o    = 1'b1;
        wdata_o = fill_q;
        fill_d  = fill_q + MAGIC_Q;
        idx_d   = idx_next;
        if (idx_q == AddrW'(Depth - 1)) begin
          state_d = KS_MIX_A;
        end
      end
      KS_MIX_A: begin
        we_o    = 1'b1;
        wdata_o = a_mix;
        a_d     = a_mix;
        state_d = KS_MIX_B;
      end
      KS_MIX_B: begin
        b_d        = b_mix;
        kw_d[kj_q] = b_mix;
        kj_d       = KjW'(kj_q + 1'b1);
        idx_d      = idx_next;
        if (step_q == StepW'(MixSteps - 1)) begin
          done_o  = 1'b1;
          state_d = KS_IDLE;
        end else begin
          step_d  = StepW'(step_q + 1'b1);
          state_d = KS_MIX_A;
        end
      end
      default: state_d = KS_IDLE;
    endcase
  end

  // The table is read at the next index so the data lands with it.
  assign raddr_o  = idx_d;
  assign waddr_o  = idx_q;
  assign active_o = (state_q != KS_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KS_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
      kj_q    <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      kj_q    <= kj_d;
    end
  end

  // Working words need no reset.
  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    a_q    <= a_d;
    b_q    <= b_d;
    kw_q   <= kw_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/rc5_datapath.sv =====
// Round datapath: whitening plus one full round per cycle, both directions.
`default_nettype none

module rc5_datapath #(
  parameter  int unsigned ROUNDS = rc5_pkg::ROUNDS_DEF,
  localparam int unsigned PairW  = $clog2(ROUNDS + 1),
  localparam int unsigned AddrW  = PairW + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  rc5_pkg::rc5_in_t           item_i,
  input  logic                       go_i,
  input  logic [rc5_pkg::WORD_W-1:0] rdata0_i,
  input  logic [rc5_pkg::WORD_W-1:0] rdata1_i,
  output logic [AddrW-1:0]           raddr0_o,
  output logic [AddrW-1:0]           raddr1_o,
  output logic                       finish_o,
  output rc5_pkg::rc5_out_t          result_o,
  output logic                       valid_o
);
  import rc5_pkg::*;

  logic              run_q, run_d;
  logic              valid_q, valid_d;
  logic              func_q, func_d;
  logic [PairW-1:0]  pair_q, pair_d;
  logic [WORD_W-1:0] a_q, a_d;
  logic [WORD_W-1:0] b_q, b_d;
  logic              func_now;
  logic              last;
  logic [WORD_W-1:0] enc_a, enc_b;
  logic [WORD_W-1:0] dec_a, dec_b;

  assign func_now = load_i ? item_i.func : func_q;

  // Encrypt round or whitening for the subkey pair now on the read ports.
  always_comb begin
    if (pair_q == '0) begin
      enc_a = a_q + rdata0_i;
      enc_b = b_q + rdata1_i;
    end else begin
      enc_a = rotl(a_q ^ b_q, b_q[ROT_W-1:0]) + rdata0_i;
      enc_b = rotl(b_q ^ enc_a, enc_a[ROT_W-1:0]) + rdata1_i;
    end
  end

  // Decrypt round or final unwhitening.
  always_comb begin
    if (pair_q == '0) begin
      dec_a = a_q - rdata0_i;
      dec_b = b_q - rdata1_i;
    end else begin
      dec_b = rotr(b_q - rdata1_i, a_q[ROT_W-1:0]) ^ a_q;
      dec_a = rotr(a_q - rdata0_i, dec_b[ROT_W-1:0]) ^ dec_b;
    end
  end

  assign last = (func_q == FUNC_ENC) ? (pair_q == PairW'(ROUNDS)) : (pair_q == '0);

  // Round counter, working words and result strobe.
  always_comb begin
    run_d   = run_q;
    valid_d = 1'b0;
    func_d  = func_q;
    pair_d  = pair_q;
    a_d     = a_q;
    b_d     = b_q;
    if (load_i) begin
      func_d = item_i.func;
      a_d    = item_i.block_a;
      b_d    = item_i.block_b;
    end
    if (go_i) begin
      run_d  = 1'b1;
      pair_d = (func_now == FUNC_ENC) ? '0 : PairW'(ROUNDS);
    end else if (run_q) begin
      a_d = (func_q == FUNC_ENC) ? enc_a : dec_a;
      b_d = (func_q == FUNC_ENC) ? enc_b : dec_b;
      if (last) begin
        run_d   = 1'b0;
        valid_d = 1'b1;
      end else if (func_q == FUNC_ENC) begin
        pair_d = PairW'(pair_q + 1'b1);
      end else begin
        pair_d = PairW'(pair_q - 1'b1);
      end
    end
  end

  // Read the pair needed in the next cycle.
  assign raddr0_o = {pair_d, 1'b0};
  assign raddr1_o = {pair_d, 1'b1};
  assign finish_o = run_q && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      valid_q <= 1'b0;
      pair_q  <= '0;
    end else begin
      run_q   <= run_d;
      valid_q <= valid_d;
      pair_q  <= pair_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    a_q    <= a_d;
    b_q    <= b_d;
  end

  assign result_o.out_a = a_q;
  assign result_o.out_b = b_q;
  assign valid_o        = valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/rc5_block_cipher_top.sv =====
// RC5-32 block cipher top level: key registers, control and subkey table.
// An accepted beat shows its result for one cycle; the next beat is taken at the edge that ends
// that cycle, and no new beat is taken before the previous result has shown.
// The first beat after reset or a key write first waits for key expansion: a fill pass over
// the 2*ROUNDS+2 table words, then 3*max(2*ROUNDS+2, 4) mixing steps.
// Reset clears control state and the key registers; the subkey table is rebuilt before use.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
`default_nettype none

module rc5_block_cipher_top #(
  parameter  int unsigned ROUNDS = rc5_pkg::ROUNDS_DEF,
  localparam int unsigned AddrW  = $clog2(2 * ROUNDS + 2)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [rc5_pkg::KEY_W-1:0] cfg_wdata_i,
  input  logic                      start,
  output logic                      busy,
  input  rc5_pkg::rc5_in_t          in_i,
  output logic                      result_valid_o,
  output rc5_pkg::rc5_out_t         result_o
);
  import rc5_pkg::*;

  rc5_top_state_e    state_q, state_d;
  logic [KEY_W-1:0]  key_low_q;
  logic [KEY_W-1:0]  key_high_q;
  logic              sched_valid_q;
  logic              accept;
  logic              ks_start;
  logic              dp_go;
  logic              ks_active;
  logic              ks_done;
  logic              dp_finish;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AddrW-1:0]  ks_raddr;
  logic [AddrW-1:0]  dp_raddr0;
  logic [AddrW-1:0]  dp_raddr1;
  logic [AddrW-1:0]  ram_raddr0;
  logic [WORD_W-1:0] ram_rdata0;
  logic [WORD_W-1:0] ram_rdata1;

  assign accept = start && !busy;
  assign busy   = (state_q != TOP_IDLE);

  // Key registers; any key write invalidates the subkey table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q     <= '0;
      key_high_q    <= '0;
      sched_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        CFG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        default:      key_low_q  <= key_low_q;
      endcase
      sched_valid_q <= 1'b0;
    end else if (ks_done) begin
      sched_valid_q <= 1'b1;
    end
  end

  // Control: expand the key when needed, then run the cipher.
  always_comb begin
    state_d  = state_q;
    ks_start = 1'b0;
    dp_go    = 1'b0;
    unique case (state_q)
      TOP_IDLE: begin
        if (accept) begin
          if (sched_valid_q) begin
            dp_go   = 1'b1;
            state_d = TOP_CIPHER;
          end else begin
            ks_start = 1'b1;
            state_d  = TOP_EXPAND;
          end
        end
      end
      TOP_EXPAND: begin
        if (ks_done) begin
          dp_go   = 1'b1;
          state_d = TOP_CIPHER;
        end
      end
      TOP_CIPHER: begin
        if (dp_finish) begin
          state_d = TOP_IDLE;
        end
      end
      default: state_d = TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TOP_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Read port 0 belongs to the key schedule while it fills and mixes, until its done strobe.
  assign ram_raddr0 = (ks_active && !ks_done) ? ks_raddr : dp_raddr0;

  rc5_subkey_ram #(
    .ROUNDS(ROUNDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr0_i(ram_raddr0),
    .raddr1_i(dp_raddr1),
    .rdata0_o(ram_rdata0),
    .rdata1_o(ram_rdata1)
  );

  rc5_key_sched #(
    .ROUNDS(ROUNDS)
  ) u_key_sched (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ks_start),
    .key_low_i (key_low_q),
    .key_high_i(key_high_q),
    .rdata_i   (ram_rdata0),
    .raddr_o   (ks_raddr),
    .we_o      (ram_we),
    .waddr_o   (ram_waddr),
    .wdata_o   (ram_wdata),
    .active_o  (ks_active),
    .done_o    (ks_done)
  );

  rc5_datapath #(
    .ROUNDS(ROUNDS)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .item_i  (in_i),
    .go_i    (dp_go),
    .rdata0_i(ram_rdata0),
    .rdata1_i(ram_rdata1),
    .raddr0_o(dp_raddr0),
    .raddr1_o(dp_raddr1),
    .finish_o(dp_finish),
    .result_o(result_o),
    .valid_o (result_valid_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rc5_checker.sv =====
// Port-level checks for the RC5 top level, attached by a bind statement.
`default_nettype none

module rc5_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);

  // An accepted beat keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  // A result strobe lasts exactly one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  // A result only ends a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a busy period");

  // Busy only drops together with a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result");

endmodule

bind rc5_block_cipher_top rc5_checker u_rc5_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the RC5-32 block cipher: keys, directed and random blocks.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rc5_pkg::*;

  localparam int unsigned ROUNDS      = ROUNDS_DEF;
  localparam int unsigned TABLE_LEN   = 2 * ROUNDS + 2;
  localparam int unsigned MIX_LEN     = 3 * ((TABLE_LEN > KEY_WORDS) ? TABLE_LEN : KEY_WORDS);
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 163;
  localparam int unsigned CYCLE_LIMIT = 250000;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_BLOCK,
    CMD_KEY,
    CMD_DRAIN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    rc5_in_t           blk;
    rc5_cfg_idx_e      idx;
    logic [KEY_W-1:0]  key;
    logic [3:0]        gap;
  } cmd_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_idx_i   = 1'b0;
  logic [KEY_W-1:0]  cfg_wdata_i = '0;
  logic              start       = 1'b0;
  logic              busy;
  rc5_in_t           in_beat     = '0;
  logic              result_valid_o;
  rc5_out_t          result_o;

  // Commands waiting for the driver and cipher outputs waiting for the monitor.
  cmd_t              pending[$];
  rc5_out_t          expected_blocks[$];

  // Predictor state: key registers and the expanded subkey table.
  logic [KEY_W-1:0]  key_lo_m = '0;
  logic [KEY_W-1:0]  key_hi_m = '0;
  word_t             sched[TABLE_LEN];
  bit                sched_ok = 1'b0;

  int unsigned       errors = 0;
  int unsigned       cycle_count = 0;
  int unsigned       idle_left = 0;
  int unsigned       quiet_cycles = 0;
  bit                gap_loaded = 1'b0;
  bit                idle_on = 1'b1;

  rc5_block_cipher_top #(
    .ROUNDS(ROUNDS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .in_i           (in_beat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Rotations take the low five bits of the amount; zero leaves the word as is.
  function automatic word_t rol_word(word_t x, word_t amt);
    int unsigned s;
    s = amt[ROT_W-1:0];
    if (s == 0) return x;
    return (x << s) | (x >> (WORD_W - s));
  endfunction

  function automatic word_t ror_word(word_t x, word_t amt);
    int unsigned s;
    s = amt[ROT_W-1:0];
    if (s == 0) return x;
    return (x >> s) | (x << (WORD_W - s));
  endfunction

  // Build the subkey table from the current key registers.
  function automatic void expand_schedule();
    word_t       kw[KEY_WORDS];
    word_t       a;
    word_t       b;
    int unsigned ti;
    int unsigned kj;
    a  = '0;
    b  = '0;
    ti = 0;
    kj = 0;
    kw[0] = key_lo_m[WORD_W-1:0];
    kw[1] = key_lo_m[KEY_W-1:WORD_W];
    kw[2] = key_hi_m[WORD_W-1:0];
    kw[3] = key_hi_m[KEY_W-1:WORD_W];
    sched[0] = MAGIC_P;
    for (int n = 1; n < TABLE_LEN; n++) sched[n] = sched[n-1] + MAGIC_Q;
    for (int st = 0; st < MIX_LEN; st++) begin
      a = rol_word(sched[ti] + a + b, 3);
      sched[ti] = a;
      b = rol_word(kw[kj] + a + b, a + b);
      kw[kj] = b;
      ti = (ti + 1 == TABLE_LEN) ? 0 : ti + 1;
      kj = (kj + 1) % KEY_WORDS;
    end
    sched_ok = 1'b1;
  endfunction

  // Expected output block for one accepted beat.
  function automatic rc5_out_t predict_block(rc5_in_t beat);
    word_t    a;
    word_t    b;
    rc5_out_t res;
    if (!sched_ok) expand_schedule();
    a = beat.block_a;
    b = beat.block_b;
    if (beat.func == FUNC_ENC) begin
      a = a + sched[0];
      b = b + sched[1];
      for (int i = 1; i <= ROUNDS; i++) begin
        a = rol_word(a ^ b, b) + sched[2*i];
        b = rol_word(b ^ a, a) + sched[2*i+1];
      end
    end else begin
      for (int i = ROUNDS; i > 0; i--) begin
        b = ror_word(b - sched[2*i+1], a) ^ a;
        a = ror_word(a - sched[2*i], b) ^ b;
      end
      b = b - sched[1];
      a = a - sched[0];
    end
    res.out_a = a;
    res.out_b = b;
    return res;
  endfunction

  task automatic add_block(input logic fn, input word_t a, input word_t b);
    cmd_t c;
    c = '0;
    c.kind = CMD_BLOCK;
    c.blk.func = fn;
    c.blk.block_a = a;
    c.blk.block_b = b;
    c.gap = idle_on ? 4'($urandom_range(0, 8)) : 4'd0;
    pending.push_back(c);
  endtask

  task automatic add_key(input rc5_cfg_idx_e idx, input logic [KEY_W-1:0] value);
    cmd_t c;
    c = '0;
    c.kind = CMD_KEY;
    c.idx = idx;
    c.key = value;
    pending.push_back(c);
  endtask

  task automatic add_drain();
    cmd_t c;
    c = '0;
    c.kind = CMD_DRAIN;
    pending.push_back(c);
  endtask

  // Mostly random words, with the all-zero and all-one words mixed in.
  function automatic word_t pick_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Driver: issues blocks after their gap, key writes and drains only when quiet.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    cmd_t head;
    logic launch;
    logic write_key;
    if (!rst_ni) begin
      start      <= 1'b0;
      cfg_we_i   <= 1'b0;
      idle_left    = 0;
      gap_loaded   = 1'b0;
      quiet_cycles = 0;
    end else begin
      launch    = start;
      write_key = 1'b0;
      // A key write lands at this edge and invalidates the schedule.
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_KEY_LOW) key_lo_m = cfg_wdata_i;
        else key_hi_m = cfg_wdata_i;
        sched_ok = 1'b0;
      end
      // Beat accepted: record its expected output.
      if (start && !busy) begin
        expected_blocks.push_back(predict_block(in_beat));
        launch = 1'b0;
      end
      if (!start && !busy && expected_blocks.size() == 0) quiet_cycles++;
      else quiet_cycles = 0;
      if (!launch && pending.size() != 0) begin
        head = pending[0];
        case (head.kind)
          CMD_BLOCK: begin
            if (!gap_loaded) begin
              idle_left  = head.gap;
              gap_loaded = 1'b1;
            end
            if (idle_left != 0) begin
              idle_left--;
            end else begin
              in_beat   <= head.blk;
              launch     = 1'b1;
              gap_loaded = 1'b0;
              void'(pending.pop_front());
            end
          end
          CMD_KEY: begin
            if (quiet_cycles >= SETTLE) begin
              cfg_idx_i   <= head.idx;
              cfg_wdata_i <= head.key;
              write_key    = 1'b1;
              void'(pending.pop_front());
            end
          end
          default: begin
            if (quiet_cycles >= SETTLE) void'(pending.pop_front());
          end
        endcase
      end
      start    <= launch;
      cfg_we_i <= write_key;
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin : watch_proc
    rc5_out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h_%h",
                 $time, result_o.out_a, result_o.out_b);
        errors++;
      end else begin
        want = expected_blocks.pop_front();
        if (result_o.out_a !== want.out_a) begin
          $display("%0t: out_a mismatch, expected %h, actual %h",
                   $time, want.out_a, result_o.out_a);
          errors++;
        end
        if (result_o.out_b !== want.out_b) begin
          $display("%0t: out_b mismatch, expected %h, actual %h",
                   $time, want.out_b, result_o.out_b);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic fn;
    // Data before any key write runs on the all-zero reset key.
    add_block(FUNC_ENC, 32'h0000_0000, 32'h0000_0000);
    add_block(FUNC_DEC, 32'h0000_0000, 32'h0000_0000);
    add_block(FUNC_ENC, 32'hffff_ffff, 32'hffff_ffff);
    add_block(FUNC_DEC, 32'hffff_ffff, 32'hffff_ffff);
    add_block(FUNC_ENC, 32'h0000_0000, 32'hffff_ffff);
    add_block(FUNC_DEC, 32'hffff_ffff, 32'h0000_0000);
    add_block(FUNC_ENC, 32'h8000_0000, 32'h0000_0001);
    add_block(FUNC_DEC, 32'h0000_0001, 32'h8000_0000);
    add_block(FUNC_ENC, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
    add_block(FUNC_DEC, 32'h5a5a_5a5a, 32'ha5a5_a5a5);
    // Rotate amounts of zero in the first half-round when the low bits match.
    add_block(FUNC_ENC, 32'h4c1e_aeba, 32'h0000_0020);
    add_block(FUNC_DEC, 32'h1234_5660, 32'h0000_0000);
    // All-one key.
    add_key(CFG_KEY_LOW, '1);
    add_key(CFG_KEY_HIGH, '1);
    add_block(FUNC_ENC, 32'h0000_0000, 32'h0000_0000);
    add_block(FUNC_DEC, 32'hffff_ffff, 32'hffff_ffff);
    add_block(FUNC_ENC, 32'hffff_ffff, 32'h0000_0000);
    add_block(FUNC_DEC, 32'h0000_0000, 32'hffff_ffff);

    // Random phases, each under its own key and idling pattern.
    for (int phase = 0; phase < PHASES; phase++) begin
      idle_on = (phase % 3 != 2);
      case (phase)
        0: begin
          add_key(CFG_KEY_LOW, '0);
          add_key(CFG_KEY_HIGH, '0);
        end
        2: add_key(CFG_KEY_LOW, {$urandom, $urandom});
        3: add_key(CFG_KEY_HIGH, {$urandom, $urandom});
        4: begin
          add_key(CFG_KEY_LOW, 64'h0000_0000_0000_0001);
          add_key(CFG_KEY_HIGH, 64'h8000_0000_0000_0000);
        end
        5: begin
          add_key(CFG_KEY_LOW, '1);
          add_key(CFG_KEY_HIGH, '1);
        end
        6: begin
          add_key(CFG_KEY_LOW, 64'h0123_4567_89ab_cdef);
          add_key(CFG_KEY_HIGH, 64'hfedc_ba98_7654_3210);
        end
        default: begin
          add_key(CFG_KEY_LOW, {$urandom, $urandom});
          add_key(CFG_KEY_HIGH, {$urandom, $urandom});
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // The sender holds off until the block has drained.
        if (phase % 2 == 0 && n == PHASE_ITEMS / 2) add_drain();
        fn = $urandom_range(0, 1) ? FUNC_DEC : FUNC_ENC;
        add_block(fn, pick_word(), pick_word());
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || start || expected_blocks.size() != 0) @(posedge clk_i);
    repeat (ROUNDS + 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
